@@ hdl/depth_to_normal_map_defines.svh @@
// Assertion macros for the depth-to-normal-map checker.
`ifndef DEPTH_TO_NORMAL_MAP_DEFINES_SVH
`define DEPTH_TO_NORMAL_MAP_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define DNM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, ignored while reset is held.
`define DNM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hdl/dnm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dnm_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 12;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd640;
  localparam logic [15:0]        GAIN_RESET  = 16'd256;
  localparam logic [23:0]        FLAT_NORMAL = 24'hff8080;

  // D = 255 * 256, the slope divisor, and its square
  localparam logic [31:0] SLOPE_DIV_SQ = 32'd4261478400;

  // Arithmetic widths of the normal unit
  localparam int MAG_W = 23;              // |diff * gain|
  localparam int SQ_W  = 2 * MAG_W;       // its square
  localparam int S_W   = SQ_W + 2;        // sum of squares
  localparam int Q_W   = S_W + 8;         // q * S
  localparam int P_W   = S_W + 18;        // q^2 * S and trial values

  localparam int STEPS = 8;               // result bits per component

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH = 2'd0,
    CFG_GAIN_UP     = 2'd1,
    CFG_GAIN_RIGHT  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] depth_sample;
    logic       frame_start;
  } dnm_in_t;

  typedef struct packed {
    logic [31:0] bump_word;
    logic        last_of_run;
  } dnm_out_t;

  typedef struct packed {
    logic       capture;
    logic       latch_above;
    logic       mul;
    logic       square;
    logic       sum;
    logic       iter;
    logic [2:0] bit_idx;
    logic       load_a;
    logic       load_b;
    logic       commit;
  } dnm_cmd_t;

  typedef struct packed {
    logic has_a;
    logic a_normal;
    logic has_b;
  } dnm_status_t;

endpackage
`default_nettype wire

@@ hdl/dnm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/dnm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dnm_ctrl
  import dnm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  wire dnm_status_t status,
  output dnm_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_MUL, ST_SQ, ST_SUM, ST_IT, ST_LA, ST_OA, ST_OB, ST_CM
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // sequence one pixel through read, normal unit and result beats
  always_comb begin
    state_nxt     = state_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.bit_idx   = bit_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_RD;
        end
      end
      ST_RD: begin
        cmd.latch_above = 1'b1;
        if (status.has_a && status.a_normal) begin
          state_nxt = ST_MUL;
        end else if (status.has_a) begin
          cmd.load_a    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_OA;
        end else if (status.has_b) begin
          cmd.load_b    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_OB;
        end else begin
          state_nxt = ST_CM;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        bit_nxt   = 3'(STEPS - 1);
        state_nxt = ST_IT;
      end
      ST_IT: begin
        cmd.iter = 1'b1;
        bit_nxt  = bit_r - 3'd1;
        if (bit_r == 3'd0) begin
          state_nxt = ST_LA;
        end
      end
      ST_LA: begin
        cmd.load_a    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OA;
      end
      ST_OA: begin
        if (!out_stall) begin
          if (status.has_b) begin
            cmd.load_b = 1'b1;
            state_nxt  = ST_OB;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_CM;
          end
        end
      end
      ST_OB: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_CM;
        end
      end
      ST_CM: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold state, bit counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dnm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dnm_datapath
  import dnm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dnm_in_t     in_data,
  output dnm_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire dnm_cmd_t    cmd,
  output dnm_status_t      status
);

  // configuration
  logic [WIDTH_W-1:0] width_r;
  logic signed [15:0] gain_up_r, gain_right_r;

  // stream state
  logic [COL_W-1:0] col_r;
  logic             first_row_r;
  logic             held_valid_r;
  logic [7:0]       held_pixel_r, held_above_r;

  // current pixel
  logic [7:0]       v_r, above_r;
  logic [COL_W-1:0] cur_col_r;
  logic             eff_first_r;
  dnm_status_t      status_r;

  // normal unit
  logic                    neg_a_r, neg_b_r;
  logic signed [24:0]      a_r, b_r;
  logic [SQ_W-1:0]         a2_r, b2_r;
  logic [S_W-1:0]          s_r;
  logic [P_W-1:0]          p_r [3];
  logic [Q_W-1:0]          qs_r [3];
  logic [7:0]              q_r [3];

  logic [31:0] out_word_r;
  logic        out_last_r;

  logic [COL_W-1:0]   col0;
  logic               fs_first;
  logic [WIDTH_W-1:0] wc;
  logic [7:0]         ram_rdata;
  logic signed [8:0]  du, dr;
  logic signed [24:0] a_w, b_w;
  logic [MAG_W-1:0]   a_mag, b_mag;
  logic [P_W-1:0]     trial [3];
  logic [P_W-1:0]     rhs [3];
  logic [SQ_W+1:0]    num2 [3];
  logic [8:0]         comp [3];
  logic [7:0]         nclamp [3];
  logic [4:0]         sh_q, sh_s;

  assign status   = status_r;
  assign out_data = '{bump_word: out_word_r, last_of_run: out_last_r};

  // frame start restarts the column count and the first row
  assign col0     = in_data.frame_start ? '0 : col_r;
  assign fs_first = in_data.frame_start | first_row_r;

  // clamp the configured width into the supported range
  always_comb begin
    wc = width_r;
    if (width_r < WIDTH_W'(2)) begin
      wc = WIDTH_W'(2);
    end else if (width_r > WIDTH_W'(MAX_WIDTH)) begin
      wc = WIDTH_W'(MAX_WIDTH);
    end
  end

  dnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (cmd.latch_above),
    .waddr (cur_col_r),
    .wdata (v_r),
    .raddr (col0),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= WIDTH_RESET;
      gain_up_r    <= GAIN_RESET;
      gain_right_r <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH: width_r      <= cfg_data[WIDTH_W-1:0];
        CFG_GAIN_UP:     gain_up_r    <= cfg_data;
        CFG_GAIN_RIGHT:  gain_right_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stream state: advance at the end of each pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      first_row_r  <= 1'b1;
      held_valid_r <= 1'b0;
      held_pixel_r <= '0;
      held_above_r <= '0;
    end else if (cmd.commit) begin
      if (status_r.has_b) begin
        col_r        <= '0;
        first_row_r  <= 1'b0;
        held_valid_r <= 1'b0;
      end else begin
        col_r        <= cur_col_r + COL_W'(1);
        first_row_r  <= eff_first_r;
        held_valid_r <= 1'b1;
        held_pixel_r <= v_r;
        held_above_r <= above_r;
      end
    end
  end

  // capture the pixel and decide which results it causes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
    end else if (cmd.capture) begin
      status_r.has_a    <= held_valid_r;
      status_r.a_normal <= !fs_first;
      status_r.has_b    <= ({1'b0, col0} >= wc - WIDTH_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      v_r         <= in_data.depth_sample;
      cur_col_r   <= col0;
      eff_first_r <= fs_first;
    end
    if (cmd.latch_above) begin
      above_r <= ram_rdata;
    end
  end

  // slopes: difference times gain
  assign du    = $signed({1'b0, held_above_r}) - $signed({1'b0, held_pixel_r});
  assign dr    = $signed({1'b0, v_r}) - $signed({1'b0, held_pixel_r});
  assign a_w   = du * gain_up_r;
  assign b_w   = dr * gain_right_r;
  assign a_mag = a_r[24] ? MAG_W'(-a_r) : MAG_W'(a_r);
  assign b_mag = b_r[24] ? MAG_W'(-b_r) : MAG_W'(b_r);

  // numerators squared, per lane
  assign num2[0] = (SQ_W+2)'(a2_r);
  assign num2[1] = (SQ_W+2)'(b2_r);
  assign num2[2] = (SQ_W+2)'(SLOPE_DIV_SQ);

  assign sh_q = 5'(cmd.bit_idx) + 5'd1;
  assign sh_s = {1'b0, cmd.bit_idx, 1'b0};

  // one result bit per lane: try (q + 2^k)^2 * S against 2^14 * num^2
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      trial[l] = p_r[l] + (P_W'(qs_r[l]) << sh_q) + (P_W'(s_r) << sh_s);
      rhs[l]   = P_W'(num2[l]) << 14;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      a_r <= a_w;
      b_r <= b_w;
    end
    if (cmd.square) begin
      a2_r    <= a_mag * a_mag;
      b2_r    <= b_mag * b_mag;
      neg_a_r <= a_r[24];
      neg_b_r <= b_r[24];
    end
    if (cmd.sum) begin
      s_r <= S_W'(a2_r) + S_W'(b2_r) + S_W'(SLOPE_DIV_SQ);
      for (int l = 0; l < 3; l++) begin
        p_r[l]  <= '0;
        qs_r[l] <= '0;
        q_r[l]  <= '0;
      end
    end
    if (cmd.iter) begin
      for (int l = 0; l < 3; l++) begin
        if (trial[l] <= rhs[l]) begin
          p_r[l]               <= trial[l];
          qs_r[l]              <= qs_r[l] + (Q_W'(s_r) << cmd.bit_idx);
          q_r[l][cmd.bit_idx]  <= 1'b1;
        end
      end
    end
  end

  // quantise: a non-negative slope subtracts, a negative one adds, the z lane adds; clamp at 255
  always_comb begin
    comp[0] = neg_a_r ? 9'd128 + 9'(q_r[0]) : 9'd128 - 9'(q_r[0]);
    comp[1] = neg_b_r ? 9'd128 + 9'(q_r[1]) : 9'd128 - 9'(q_r[1]);
    comp[2] = 9'd128 + 9'(q_r[2]);
    for (int l = 0; l < 3; l++) begin
      nclamp[l] = comp[l][8] ? 8'hff : comp[l][7:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      out_last_r <= !status_r.has_b;
      if (status_r.a_normal) begin
        out_word_r <= {held_pixel_r, nclamp[2], nclamp[1], nclamp[0]};
      end else begin
        out_word_r <= {held_pixel_r, FLAT_NORMAL};
      end
    end else if (cmd.load_b) begin
      out_last_r <= 1'b1;
      out_word_r <= {v_r, FLAT_NORMAL};
    end
  end

endmodule
`default_nettype wire

@@ hdl/depth_to_normal_map.sv @@
// Depth to normal map: one 8-bit depth pixel in, in raster order, and a 32-bit word
// out per pixel (depth, nz, nx, ny from the top byte down), one pixel late since a
// pixel needs its right neighbour. A pixel that closes a row releases two words.
// A pixel passes through capture, row store read and commit, with a result state for
// each word it releases. When its held neighbour gets a normal, multiply, square,
// sum, the bit steps of the normal unit and a load come between the read and the
// first word. A stalled output holds the result word. The normal unit finds each
// component one bit per cycle, three lanes in parallel. The row store needs no
// clearing pass. Write configuration only while idle.
`timescale 1ns / 1ps
`default_nettype none
module depth_to_normal_map
  import dnm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire dnm_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output dnm_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dnm_cmd_t    cmd;
  dnm_status_t status;

  assign cfg_ready = 1'b1;

  dnm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dnm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

@@ hdl/dnm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "depth_to_normal_map_defines.svh"
module dnm_checker
  import dnm_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire dnm_out_t out_data
);

  // a stalled result beat stays offered
  `DNM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // an accepted pixel blocks the input while it is worked on
  `DNM_ASSERT_NXT(a_in_busy, clk, rst_n, in_valid && !in_stall, in_stall)
  // no pixel is taken while a result waits
  `DNM_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, in_stall)
  // a beat that is not the last of its run is followed at once by another
  `DNM_ASSERT_NXT(a_run_cont, clk, rst_n,
                  out_valid && !out_stall && !out_data.last_of_run, out_valid)

endmodule

bind depth_to_normal_map dnm_checker u_dnm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
